// ===== hdl/prac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_pkg
// shared types and codes of the port range access control checker
// ----------------------------------------------------------------------------
package prac_pkg;

   localparam int PORT_W = 16;

   localparam logic REQ_CHECK = 1'b0;
   localparam logic REQ_ADD   = 1'b1;

   localparam logic [1:0] AUDIT_NONE  = 2'd0;
   localparam logic [1:0] AUDIT_GRANT = 2'd1;
   localparam logic [1:0] AUDIT_DENY  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic [1:0] CSR_CHECK_ENABLED  = 2'd0;
   localparam logic [1:0] CSR_ENFORCE_MODE   = 2'd1;
   localparam logic [1:0] CSR_LEARN_MODE     = 2'd2;
   localparam logic [1:0] CSR_TRUSTED_DOMAIN = 2'd3;

   typedef struct packed {
      logic check_enabled;
      logic enforce_mode;
      logic learn_mode;
      logic trusted_domain;
   } cfg_type;

   typedef struct packed {
      logic              req_type;
      logic              proto_tcp;
      logic [PORT_W-1:0] port_low;
      logic [PORT_W-1:0] port_high;
   } request_type;

   typedef struct packed {
      logic       allowed;
      logic [1:0] audit_kind;
      logic [1:0] status;
      logic       learned;
   } result_type;

   typedef struct packed {
      logic              proto;
      logic [PORT_W-1:0] port_low;
      logic [PORT_W-1:0] port_high;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_MISS,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/prac_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_if
// request, response and register write channels of the checker
// ----------------------------------------------------------------------------
interface prac_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        proto_tcp;
   logic [15:0] port_low;
   logic [15:0] port_high;
   modport source (output valid, req_type, proto_tcp, port_low, port_high, input ready);
   modport sink (input valid, req_type, proto_tcp, port_low, port_high, output ready);
endinterface

interface prac_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [1:0] audit_kind;
   logic [1:0] status;
   logic       learned;
   modport source (output valid, allowed, audit_kind, status, learned, input ready);
   modport sink (input valid, allowed, audit_kind, status, learned, output ready);
endinterface

interface prac_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/prac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module prac_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/prac_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_cmp
// shared range comparator: does one table entry cover the requested range
// ----------------------------------------------------------------------------
module prac_cmp
   import prac_pkg::*;
(
   input  entry_type         ent,
   input  logic              proto,
   input  logic [PORT_W-1:0] lo,
   input  logic [PORT_W-1:0] hi,
   output logic              hit
);

   assign hit = (ent.proto == proto) && (ent.port_low <= lo) && (hi <= ent.port_high);

endmodule

// ===== hdl/prac_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_seq
// sequencer that walks the range table through one comparator
// ----------------------------------------------------------------------------
module prac_seq
   import prac_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  request_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_data,
   output logic        ram_rd_en,
   output logic [AW-1:0] ram_rd_addr,
   input  entry_type   ram_rd_data,
   output logic        ram_wr_en,
   output logic [AW-1:0] ram_wr_addr,
   output entry_type   ram_wr_data
);

   state_type   state_ff, state_in;
   request_type req_ff, req_in;
   result_type  res_ff, res_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic        rd_valid_ff, rd_valid_in;

   logic early;
   logic issue;
   logic hit;
   logic cmp_hit;
   logic walk_done;
   logic full;

   prac_cmp u_cmp (
      .ent   (ram_rd_data),
      .proto (req_ff.proto_tcp),
      .lo    (req_ff.port_low),
      .hi    (req_ff.port_high),
      .hit   (cmp_hit)
   );

   assign early = (req_ff.req_type == REQ_CHECK)
                  ? (!cfg.check_enabled || cfg.trusted_domain)
                  : (req_ff.port_low > req_ff.port_high);
   assign issue     = idx_ff < count_ff;
   assign hit       = rd_valid_ff && cmp_hit;
   assign walk_done = !issue && !rd_valid_ff;
   assign full      = count_ff >= CW'(TABLE_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = early ? ST_RESP : ST_WALK;
         end
         ST_WALK: begin
            if (hit) state_in = ST_RESP;
            else if (walk_done) state_in = ST_MISS;
         end
         ST_MISS: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      req_in      = req_ff;
      res_in      = res_ff;
      idx_in      = idx_ff;
      rd_valid_in = 1'b0;
      count_in    = count_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = '{proto: req_ff.proto_tcp, port_low: req_ff.port_low,
                      port_high: req_ff.port_high};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            req_in    = req_data;
            if (req_data.req_type == REQ_CHECK) begin
               req_in.port_high = req_data.port_low;
            end
         end
         ST_DECIDE: begin
            idx_in = '0;
            res_in = '{allowed: 1'b0, audit_kind: AUDIT_NONE, status: STATUS_OK,
                       learned: 1'b0};
            if (req_ff.req_type == REQ_CHECK) begin
               res_in.allowed = 1'b1;
               if (cfg.check_enabled) res_in.audit_kind = AUDIT_GRANT;
            end else begin
               res_in.status = STATUS_BAD_RANGE;
            end
         end
         ST_WALK: begin
            ram_rd_en   = issue;
            rd_valid_in = issue;
            idx_in      = idx_ff + CW'(issue);
            res_in = '{allowed: 1'b1, audit_kind: AUDIT_NONE, status: STATUS_OK,
                       learned: 1'b0};
            if (req_ff.req_type == REQ_CHECK) res_in.audit_kind = AUDIT_GRANT;
         end
         ST_MISS: begin
            res_in = '{allowed: 1'b0, audit_kind: AUDIT_NONE, status: STATUS_OK,
                       learned: 1'b0};
            if (req_ff.req_type == REQ_CHECK) begin
               res_in.audit_kind = AUDIT_DENY;
               if (!cfg.enforce_mode) begin
                  res_in.allowed = 1'b1;
                  if (cfg.learn_mode) begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        res_in.learned = 1'b1;
                        ram_wr_en      = 1'b1;
                        count_in       = count_ff + CW'(1);
                     end
                  end
               end
            end else begin
               if (full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  res_in.allowed = 1'b1;
                  res_in.learned = 1'b1;
                  ram_wr_en      = 1'b1;
                  count_in       = count_ff + CW'(1);
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      if (state_ff != ST_RESP) begin
         res_ff <= res_in;
      end
   end

   assign rsp_data = res_ff;

endmodule

// ===== hdl/port_range_acl_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_range_acl_checker_unit
// connect port permission table for one security domain
// ----------------------------------------------------------------------------
// One transaction at a time. A request that needs no table lookup (checking
// off, trusted domain, or an add with low above high) goes from the decide
// state straight to the response. Otherwise a single range comparator walks
// the stored entries one per cycle out of a RAM with registered read, up to
// the first hit or, on a miss, through every stored entry and the miss state,
// and the response then waits for rsp_if.ready; the next request can be
// taken in the cycle after the response is accepted. The table needs no
// clearing after reset; only entries below the fill count are ever read.
// Register writes are taken at any time and should be made while no
// transaction is in flight.
module port_range_acl_checker_unit
   import prac_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input logic          clock,
   input logic          reset,
   prac_req_if.sink     req_if,
   prac_rsp_if.source   rsp_if,
   prac_csr_if.sink     csr_if
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cfg_type     cfg_ff, cfg_in;
   request_type req_data;
   result_type  rsp_data;
   logic        ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   entry_type   ram_rd_data;
   logic        ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   entry_type   ram_wr_data;

   // register file
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_CHECK_ENABLED:  cfg_in.check_enabled  = csr_if.data;
            CSR_ENFORCE_MODE:   cfg_in.enforce_mode   = csr_if.data;
            CSR_LEARN_MODE:     cfg_in.learn_mode     = csr_if.data;
            CSR_TRUSTED_DOMAIN: cfg_in.trusted_domain = csr_if.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_data = '{req_type: req_if.req_type, proto_tcp: req_if.proto_tcp,
                       port_low: req_if.port_low, port_high: req_if.port_high};

   prac_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   prac_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   assign rsp_if.allowed    = rsp_data.allowed;
   assign rsp_if.audit_kind = rsp_data.audit_kind;
   assign rsp_if.status     = rsp_data.status;
   assign rsp_if.learned    = rsp_data.learned;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("ready held after a transaction was taken");

   a_learned_allowed: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.learned) |-> (rsp_if.allowed && rsp_if.status == STATUS_OK))
      else $error("entry appended on a refused transaction");

   a_bad_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == STATUS_BAD_RANGE)
         |-> (!rsp_if.allowed && rsp_if.audit_kind == AUDIT_NONE))
      else $error("invalid range reported as granted or audited");

endmodule

// ===== verif/port_range_acl_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_range_acl_verdict_checker
// watches the request, response and register channels of the port range
// checker, keeps its own copy of the permission table and the mode bits,
// predicts the verdict of every accepted request and compares each response
// transaction with the oldest predicted verdict
// ----------------------------------------------------------------------------
module port_range_acl_verdict_checker
   import prac_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   prac_req_if  req_mon,
   prac_rsp_if  rsp_mon,
   prac_csr_if  csr_mon,
   output int   failures,
   output int   results_seen
);

   cfg_type    acl_cfg;
   entry_type  acl_table [TABLE_DEPTH];
   int         acl_fill;
   result_type verdict_q [$];
   int         reported;

   function automatic logic acl_covers(logic proto, logic [PORT_W-1:0] lo,
                                       logic [PORT_W-1:0] hi);
      for (int i = 0; i < acl_fill; i++) begin
         if (acl_table[i].proto == proto && acl_table[i].port_low <= lo &&
             hi <= acl_table[i].port_high) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic acl_append(logic proto, logic [PORT_W-1:0] lo,
                                       logic [PORT_W-1:0] hi);
      if (acl_fill >= TABLE_DEPTH) begin
         return 1'b0;
      end
      acl_table[acl_fill] = '{proto: proto, port_low: lo, port_high: hi};
      acl_fill++;
      return 1'b1;
   endfunction

   function automatic result_type acl_decide(request_type r);
      result_type res;
      res = '{allowed: 1'b0, audit_kind: AUDIT_NONE, status: STATUS_OK, learned: 1'b0};
      if (r.req_type == REQ_CHECK) begin
         if (!acl_cfg.check_enabled) begin
            res.allowed = 1'b1;
         end else if (acl_cfg.trusted_domain) begin
            res.allowed    = 1'b1;
            res.audit_kind = AUDIT_GRANT;
         end else if (acl_covers(r.proto_tcp, r.port_low, r.port_low)) begin
            res.allowed    = 1'b1;
            res.audit_kind = AUDIT_GRANT;
         end else begin
            res.audit_kind = AUDIT_DENY;
            if (!acl_cfg.enforce_mode) begin
               res.allowed = 1'b1;
               if (acl_cfg.learn_mode) begin
                  if (acl_append(r.proto_tcp, r.port_low, r.port_low)) begin
                     res.learned = 1'b1;
                  end else begin
                     res.status = STATUS_FULL;
                  end
               end
            end
         end
      end else begin
         if (r.port_low > r.port_high) begin
            res.status = STATUS_BAD_RANGE;
         end else if (acl_covers(r.proto_tcp, r.port_low, r.port_high)) begin
            res.allowed = 1'b1;
         end else if (acl_append(r.proto_tcp, r.port_low, r.port_high)) begin
            res.allowed = 1'b1;
            res.learned = 1'b1;
         end else begin
            res.status = STATUS_FULL;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type  got;
      result_type  want;
      request_type seen;
      if (reset) begin
         acl_cfg = '0;
         acl_fill = 0;
         verdict_q.delete();
         failures = 0;
         reported = 0;
         results_seen <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_CHECK_ENABLED:  acl_cfg.check_enabled  = csr_mon.data;
               CSR_ENFORCE_MODE:   acl_cfg.enforce_mode   = csr_mon.data;
               CSR_LEARN_MODE:     acl_cfg.learn_mode     = csr_mon.data;
               CSR_TRUSTED_DOMAIN: acl_cfg.trusted_domain = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen <= results_seen + 1;
            got = '{allowed: rsp_mon.allowed, audit_kind: rsp_mon.audit_kind,
                    status: rsp_mon.status, learned: rsp_mon.learned};
            if (verdict_q.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: response transaction with no request pending", $time);
               end
            end else begin
               want = verdict_q.pop_front();
               if (got.allowed !== want.allowed || got.audit_kind !== want.audit_kind ||
                   got.status !== want.status || got.learned !== want.learned) begin
                  failures++;
                  if (reported < 10) begin
                     reported++;
                     $display("%0t: mismatch (expected/actual) allowed %0d/%0d audit %0d/%0d",
                              $time, want.allowed, got.allowed, want.audit_kind,
                              got.audit_kind);
                     $display("        status %0d/%0d learned %0d/%0d",
                              want.status, got.status, want.learned, got.learned);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seen = '{req_type: req_mon.req_type, proto_tcp: req_mon.proto_tcp,
                     port_low: req_mon.port_low, port_high: req_mon.port_high};
            verdict_q.push_back(acl_decide(seen));
         end
      end
   end

endmodule

// ===== verif/tb_port_range_acl_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_port_range_acl_checker_unit
// drives checks and range adds into the port range checker under a series of
// mode settings, with random idling on both channels and long receiver
// hold-offs; a separate checker predicts and compares every verdict
// ----------------------------------------------------------------------------
module tb_port_range_acl_checker_unit;
   import prac_pkg::*;

   localparam int   TABLE_DEPTH = 64;
   localparam int   PHASES      = 8;
   localparam int   PHASE_ITEMS = 200;
   localparam int   HOLD_CYCLES = 400;
   localparam int   STALL_LIMIT = 4000;
   localparam logic PROTO_TCP   = 1'b1;
   localparam logic PROTO_UDP   = 1'b0;

   logic clock = 1'b0;
   logic reset;

   prac_req_if req_if ();
   prac_rsp_if rsp_if ();
   prac_csr_if csr_if ();

   int        failures;
   int        results_seen;
   int        items_sent   = 0;
   int        req_idle_pct = 0;
   int        rsp_idle_pct = 0;
   int        hold_asked   = 0;
   entry_type sent_ranges [$];
   cfg_type   phase_cfg [PHASES];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   port_range_acl_checker_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   port_range_acl_verdict_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_verdict_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .csr_mon      (csr_if),
      .failures     (failures),
      .results_seen (results_seen)
   );

   function automatic request_type mk_req(logic kind, logic proto, logic [PORT_W-1:0] lo,
                                          logic [PORT_W-1:0] hi);
      return '{req_type: kind, proto_tcp: proto, port_low: lo, port_high: hi};
   endfunction

   function automatic logic [PORT_W-1:0] port_in(entry_type e);
      return e.port_low + PORT_W'($urandom_range(e.port_high - e.port_low));
   endfunction

   function automatic request_type pick_request();
      request_type       r;
      entry_type         e;
      int unsigned       sel;
      int unsigned       w;
      logic [PORT_W-1:0] a;
      r.proto_tcp = 1'($urandom_range(1));
      r.port_low  = PORT_W'($urandom);
      r.port_high = PORT_W'($urandom);
      if (sent_ranges.size() != 0) begin
         e = sent_ranges[$urandom_range(sent_ranges.size() - 1)];
      end
      sel = $urandom_range(99);
      if ($urandom_range(99) < 70) begin
         r.req_type = REQ_CHECK;
         if (sent_ranges.size() != 0 && sel < 50) begin
            r.port_low = port_in(e);
            if ($urandom_range(9) != 0) begin
               r.proto_tcp = e.proto;
            end
         end else if (sent_ranges.size() != 0 && sel < 70) begin
            // just outside a known range
            r.port_low  = $urandom_range(1) ? e.port_low - 1'b1 : e.port_high + 1'b1;
            r.proto_tcp = e.proto;
         end else if (sel < 80) begin
            r.port_low = $urandom_range(1) ? {PORT_W{1'b0}} : {PORT_W{1'b1}};
         end
      end else begin
         r.req_type = REQ_ADD;
         if (sel < 20) begin
            a           = PORT_W'($urandom_range(65535, 1));
            r.port_low  = a;
            r.port_high = PORT_W'($urandom_range(a - 1));
         end else if (sent_ranges.size() != 0 && sel < 88) begin
            a           = port_in(e);
            r.port_low  = a;
            r.port_high = a + PORT_W'($urandom_range(e.port_high - a));
            if ($urandom_range(9) != 0) begin
               r.proto_tcp = e.proto;
            end
         end else begin
            w = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(255);
            r.port_high = (int'(r.port_low) + w > 65535) ? {PORT_W{1'b1}} :
                                                          PORT_W'(int'(r.port_low) + w);
         end
      end
      return r;
   endfunction

   task automatic offer(request_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= r.req_type;
      req_if.proto_tcp <= r.proto_tcp;
      req_if.port_low  <= r.port_low;
      req_if.port_high <= r.port_high;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (r.req_type == REQ_ADD && r.port_low <= r.port_high) begin
         sent_ranges.push_back('{proto: r.proto_tcp, port_low: r.port_low,
                                 port_high: r.port_high});
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] idx, logic val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // bits: check_enabled, enforce_mode, learn_mode, trusted_domain
   task automatic set_config(cfg_type c);
      settle();
      csr_put(CSR_CHECK_ENABLED, c.check_enabled);
      csr_put(CSR_ENFORCE_MODE, c.enforce_mode);
      csr_put(CSR_LEARN_MODE, c.learn_mode);
      csr_put(CSR_TRUSTED_DOMAIN, c.trusted_domain);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : receiver
      int served;
      served = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_asked) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            served++;
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_port_range_acl_checker_unit: errors");
      $finish;
   end

   initial begin : stimulus
      int k;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_CHECK;
      req_if.proto_tcp = PROTO_UDP;
      req_if.port_low  = '0;
      req_if.port_high = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_CHECK_ENABLED;
      csr_if.data      = 1'b0;
      phase_cfg = '{4'b0000, 4'b1000, 4'b1100, 4'b1001, 4'b1010, 4'b1110, 4'b1111, 4'b1010};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // checking off after reset
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd0, 16'hffff));
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'hffff, 16'd0));

      set_config(4'b1000);
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd80, 16'd0));
      offer(mk_req(REQ_ADD, PROTO_TCP, 16'd2000, 16'd1000));
      offer(mk_req(REQ_ADD, PROTO_UDP, 16'hffff, 16'd0));
      offer(mk_req(REQ_ADD, PROTO_TCP, 16'd1000, 16'd2000));
      offer(mk_req(REQ_ADD, PROTO_TCP, 16'd1500, 16'd1600));
      offer(mk_req(REQ_ADD, PROTO_UDP, 16'd1500, 16'd1600));
      offer(mk_req(REQ_ADD, PROTO_UDP, 16'd0, 16'd0));
      offer(mk_req(REQ_ADD, PROTO_TCP, 16'hffff, 16'hffff));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd1000, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd2000, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd999, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd2001, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'd0, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'hffff, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'hffff, 16'd0));

      set_config(4'b1100);
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'd4000, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd1500, 16'd0));

      set_config(4'b1010);
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'd3000, 16'd0));
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'd3000, 16'd0));

      set_config(4'b1001);
      offer(mk_req(REQ_CHECK, PROTO_UDP, 16'd9, 16'd0));

      set_config(4'b1111);
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd7, 16'd0));

      for (int p = 0; p < PHASES; p++) begin
         set_config(phase_cfg[p]);
         if (p == 2 || p == 6) begin
            hold_asked++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            k = p * PHASE_ITEMS + n;
            if (k < PHASES * PHASE_ITEMS / 3) begin
               req_idle_pct = 10;
               rsp_idle_pct = 88;
            end else if (k < 2 * PHASES * PHASE_ITEMS / 3) begin
               req_idle_pct = 88;
               rsp_idle_pct = 10;
            end else begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            offer(pick_request());
         end
      end

      // full span add once the table has filled
      offer(mk_req(REQ_ADD, PROTO_TCP, 16'd0, 16'hffff));
      offer(mk_req(REQ_CHECK, PROTO_TCP, 16'd4660, 16'hffff));

      settle();
      repeat (TABLE_DEPTH + 10) @(posedge clock);
      if (failures == 0) begin
         $display("tb_port_range_acl_checker_unit: clean");
      end else begin
         $display("tb_port_range_acl_checker_unit: errors");
      end
      $finish;
   end

endmodule
